// ===== hdl/tevq_pkg.sv =====
// Shared types, codes and key-order function for the timed event queue.
package tevq_pkg;

    localparam int ID_W   = 64;
    localparam int TIME_W = 64;
    localparam int CNT_W  = 6;

    // Most events one advance may fire.
    localparam logic [CNT_W-1:0] MAX_FIRE = 6'd32;

    // Earliest time reported when nothing is pending.
    localparam logic signed [TIME_W-1:0] TIME_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    // Request modes.
    localparam logic [1:0] MODE_SCHED   = 2'd0;
    localparam logic [1:0] MODE_CANCEL  = 2'd1;
    localparam logic [1:0] MODE_ADVANCE = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_SCHED  = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_FIRED  = 2'd2;
    localparam logic [1:0] KIND_DONE   = 2'd3;

    typedef struct packed {
        logic [1:0]               mode;
        logic [ID_W-1:0]          ev_id;
        logic signed [TIME_W-1:0] time_value;
    } req_t;

    typedef struct packed {
        logic [1:0]               result_kind;
        logic                     status;
        logic [ID_W-1:0]          fired_id;
        logic signed [TIME_W-1:0] fired_time;
        logic [CNT_W-1:0]         fired_count;
        logic [CNT_W-1:0]         pending_count;
        logic signed [TIME_W-1:0] earliest_time;
        logic                     last;
    } rsp_t;

    // Controller to datapath.
    typedef struct packed {
        logic       scan_go;
        logic       apply;
        logic       fire;
        logic       emit;
        logic [1:0] emit_kind;
        logic       emit_last;
    } ctrl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic       scan_done;
        logic       due;
        logic [1:0] mode;
    } dp_stat_t;

    // Order by signed time, then by id.
    function automatic logic key_before(
        input logic signed [TIME_W-1:0] ta,
        input logic [ID_W-1:0]          ia,
        input logic signed [TIME_W-1:0] tb,
        input logic [ID_W-1:0]          ib
    );
        logic r;
        if (ta != tb)
        begin
            r = (ta < tb);
        end
        else
        begin
            r = (ia < ib);
        end
        return r;
    endfunction

endpackage

// ===== hdl/tevq_dp.sv =====
// Datapath: slot memory, valid bits, scan unit and result register.
module tevq_dp #(
    parameter int CAPACITY = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  tevq_pkg::req_t      req,
    input  tevq_pkg::ctrl_cmd_t cmd,
    output tevq_pkg::dp_stat_t  stat,
    output tevq_pkg::rsp_t      rsp,
    output logic                rsp_strobe
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int WORD_W = tevq_pkg::ID_W + tevq_pkg::TIME_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    tevq_pkg::req_t req_reg;
    logic [CAPACITY-1:0] valid_reg;
    logic [tevq_pkg::CNT_W-1:0] count_reg;
    logic [tevq_pkg::CNT_W-1:0] fire_cnt_reg;
    logic [WORD_W-1:0] mem [CAPACITY];

    // scan pipeline
    logic [IDX_W-1:0] addr_reg;
    logic scan_on_reg;
    logic rd_vld_reg;
    logic rd_last_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [WORD_W-1:0] rd_data_reg;

    // scan accumulators
    logic match_hit_reg;
    logic [IDX_W-1:0] match_idx_reg;
    logic free_hit_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic min_hit_reg;
    logic [IDX_W-1:0] min_idx_reg;
    logic signed [tevq_pkg::TIME_W-1:0] min_time_reg;
    logic [tevq_pkg::ID_W-1:0] min_id_reg;

    logic flag_reg;
    logic [tevq_pkg::ID_W-1:0] fired_id_reg;
    logic signed [tevq_pkg::TIME_W-1:0] fired_time_reg;
    tevq_pkg::rsp_t rsp_reg;
    logic strobe_reg;

    logic [tevq_pkg::ID_W-1:0] ent_id;
    logic signed [tevq_pkg::TIME_W-1:0] ent_time;
    logic ent_valid;
    logic is_match;
    logic is_free;
    logic is_min;
    logic wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic sched_new;
    logic signed [tevq_pkg::TIME_W-1:0] earliest_now;

    assign ent_id    = rd_data_reg[WORD_W-1:tevq_pkg::TIME_W];
    assign ent_time  = signed'(rd_data_reg[tevq_pkg::TIME_W-1:0]);
    assign ent_valid = valid_reg[rd_idx_reg];
    assign is_match  = rd_vld_reg && ent_valid && (ent_id == req_reg.ev_id);
    assign is_free   = rd_vld_reg && !ent_valid && !free_hit_reg;
    assign is_min    = rd_vld_reg && ent_valid &&
                       (!min_hit_reg ||
                        tevq_pkg::key_before(ent_time, ent_id, min_time_reg, min_id_reg));

    // the slot under evaluation in the last scan cycle still counts
    assign earliest_now = is_min ? ent_time :
                          (min_hit_reg ? min_time_reg : tevq_pkg::TIME_MAX);

    assign sched_new = !match_hit_reg && free_hit_reg;

    always_comb
    begin
        wr_en  = cmd.apply && (req_reg.mode == tevq_pkg::MODE_SCHED) &&
                 (match_hit_reg || free_hit_reg);
        wr_idx = match_hit_reg ? match_idx_reg : free_idx_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= {req_reg.ev_id, req_reg.time_value};
        end
        if (scan_on_reg)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            req_reg <= req;
        end
        if (cmd.fire)
        begin
            fired_id_reg   <= min_id_reg;
            fired_time_reg <= min_time_reg;
        end
        if (cmd.apply)
        begin
            if (req_reg.mode == tevq_pkg::MODE_SCHED)
            begin
                flag_reg <= !match_hit_reg && !free_hit_reg;
            end
            else
            begin
                flag_reg <= match_hit_reg;
            end
        end
        if (is_match)
        begin
            match_idx_reg <= rd_idx_reg;
        end
        if (is_free)
        begin
            free_idx_reg <= rd_idx_reg;
        end
        if (is_min)
        begin
            min_idx_reg  <= rd_idx_reg;
            min_time_reg <= ent_time;
            min_id_reg   <= ent_id;
        end
        if (cmd.emit)
        begin
            rsp_reg.result_kind   <= cmd.emit_kind;
            rsp_reg.status        <= ((cmd.emit_kind == tevq_pkg::KIND_SCHED) ||
                                      (cmd.emit_kind == tevq_pkg::KIND_CANCEL)) ? flag_reg : 1'b0;
            rsp_reg.fired_id      <= (cmd.emit_kind == tevq_pkg::KIND_FIRED) ?
                                     fired_id_reg : '0;
            rsp_reg.fired_time    <= (cmd.emit_kind == tevq_pkg::KIND_FIRED) ?
                                     fired_time_reg : '0;
            rsp_reg.fired_count   <= (cmd.emit_kind == tevq_pkg::KIND_DONE) ?
                                     fire_cnt_reg : '0;
            rsp_reg.pending_count <= count_reg;
            rsp_reg.earliest_time <= earliest_now;
            rsp_reg.last          <= cmd.emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            count_reg     <= '0;
            fire_cnt_reg  <= '0;
            addr_reg      <= '0;
            scan_on_reg   <= 1'b0;
            rd_vld_reg    <= 1'b0;
            rd_last_reg   <= 1'b0;
            rd_idx_reg    <= '0;
            match_hit_reg <= 1'b0;
            free_hit_reg  <= 1'b0;
            min_hit_reg   <= 1'b0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit;
            if (load)
            begin
                fire_cnt_reg <= '0;
            end

            // read side of the scan
            rd_vld_reg  <= scan_on_reg;
            rd_last_reg <= scan_on_reg && (addr_reg == LAST_IDX);
            rd_idx_reg  <= addr_reg;
            if (cmd.scan_go)
            begin
                addr_reg    <= '0;
                scan_on_reg <= 1'b1;
            end
            else if (scan_on_reg)
            begin
                addr_reg <= addr_reg + 1'b1;
                if (addr_reg == LAST_IDX)
                begin
                    scan_on_reg <= 1'b0;
                end
            end

            // accumulators
            if (cmd.scan_go)
            begin
                match_hit_reg <= 1'b0;
                free_hit_reg  <= 1'b0;
                min_hit_reg   <= 1'b0;
            end
            else
            begin
                if (is_match)
                begin
                    match_hit_reg <= 1'b1;
                end
                if (is_free)
                begin
                    free_hit_reg <= 1'b1;
                end
                if (is_min)
                begin
                    min_hit_reg <= 1'b1;
                end
            end

            // slot updates
            if (cmd.apply)
            begin
                if (req_reg.mode == tevq_pkg::MODE_SCHED)
                begin
                    if (sched_new)
                    begin
                        valid_reg[free_idx_reg] <= 1'b1;
                        count_reg <= count_reg + 1'b1;
                    end
                end
                else if (match_hit_reg)
                begin
                    valid_reg[match_idx_reg] <= 1'b0;
                    count_reg <= count_reg - 1'b1;
                end
            end
            else if (cmd.fire)
            begin
                valid_reg[min_idx_reg] <= 1'b0;
                count_reg    <= count_reg - 1'b1;
                fire_cnt_reg <= fire_cnt_reg + 1'b1;
            end
        end
    end

    assign stat.scan_done = rd_vld_reg && rd_last_reg;
    assign stat.due       = min_hit_reg && (min_time_reg <= req_reg.time_value) &&
                            (fire_cnt_reg < tevq_pkg::MAX_FIRE);
    assign stat.mode      = req_reg.mode;
    assign rsp            = rsp_reg;
    assign rsp_strobe     = strobe_reg;

`ifndef SYNTHESIS
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == $countones(valid_reg))
        else $error("pending count differs from valid bits");
    a_fire_has_min: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fire |-> (min_hit_reg && valid_reg[min_idx_reg]))
        else $error("fire without a pending earliest slot");
    a_scan_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (scan_on_reg || rd_vld_reg) |-> !(cmd.apply || cmd.fire))
        else $error("slot update during a scan");
`endif

endmodule

// ===== hdl/tevq_ctrl.sv =====
// Controller: sequences scans, updates and results for each request.
module tevq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          start_mode,
    input  tevq_pkg::dp_stat_t  stat,
    output tevq_pkg::ctrl_cmd_t cmd,
    output logic                load,
    output logic                busy
);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_LOOK     = 7'b0000010,
        ST_APPLY    = 7'b0000100,
        ST_SETTLE   = 7'b0001000,
        ST_ADV_WAIT = 7'b0010000,
        ST_ADV_EVAL = 7'b0100000,
        ST_ADV_DEC  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic pend_fire_reg, pend_fire_next;

    assign busy = (state_reg != ST_IDLE);
    assign load = start && !busy;

    always_comb
    begin
        state_next     = state_reg;
        pend_fire_next = pend_fire_reg;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                pend_fire_next = 1'b0;
                if (start)
                begin
                    if ((start_mode == tevq_pkg::MODE_SCHED) ||
                        (start_mode == tevq_pkg::MODE_CANCEL))
                    begin
                        cmd.scan_go = 1'b1;
                        state_next  = ST_LOOK;
                    end
                    else if (start_mode == tevq_pkg::MODE_ADVANCE)
                    begin
                        cmd.scan_go = 1'b1;
                        state_next  = ST_ADV_WAIT;
                    end
                end
            end
            ST_LOOK:
            begin
                if (stat.scan_done)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                cmd.apply   = 1'b1;
                cmd.scan_go = 1'b1;
                state_next  = ST_SETTLE;
            end
            ST_SETTLE:
            begin
                if (stat.scan_done)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.emit_kind = (stat.mode == tevq_pkg::MODE_SCHED) ?
                                    tevq_pkg::KIND_SCHED : tevq_pkg::KIND_CANCEL;
                    state_next    = ST_IDLE;
                end
            end
            ST_ADV_WAIT:
            begin
                if (stat.scan_done)
                begin
                    state_next = ST_ADV_EVAL;
                end
            end
            ST_ADV_EVAL:
            begin
                // the event removed before this scan goes out now
                if (pend_fire_reg)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_kind  = tevq_pkg::KIND_FIRED;
                    pend_fire_next = 1'b0;
                end
                state_next = ST_ADV_DEC;
            end
            ST_ADV_DEC:
            begin
                if (stat.due)
                begin
                    cmd.fire       = 1'b1;
                    cmd.scan_go    = 1'b1;
                    pend_fire_next = 1'b1;
                    state_next     = ST_ADV_WAIT;
                end
                else
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.emit_kind = tevq_pkg::KIND_DONE;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_fire_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_fire_reg <= pend_fire_next;
        end
    end

`ifndef SYNTHESIS
    a_emit_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.emit_last) |=> (state_reg == ST_IDLE))
        else $error("final word without return to idle");
    a_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && (cmd.emit_kind == tevq_pkg::KIND_FIRED)) |-> !cmd.emit_last)
        else $error("fired word marked last");
    a_fire_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fire |=> pend_fire_reg)
        else $error("fired event not queued for output");
`endif

endmodule

// ===== hdl/timed_event_queue.sv =====
// Timed event queue: up to CAPACITY pending events, fired earliest first.
// Schedule and cancel run a lookup scan, an update and a settle scan before the
// result; the next request can be taken while the result word is shown.
// An advance runs one scan plus evaluation per fired event and one more, then
// issues the done word; a scan reads one slot a cycle.
// The result word is held one cycle under response_strobe; no stall possible.
// Reset clears all valid bits and the controller; slot data needs no clearing.
module timed_event_queue #(
    parameter int CAPACITY = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  tevq_pkg::req_t  request,
    output tevq_pkg::rsp_t  response,
    output logic            response_strobe
);

    tevq_pkg::ctrl_cmd_t cmd;
    tevq_pkg::dp_stat_t  stat;
    logic                load;

    // Sequencer: one request at a time, busy until its last word is issued.
    tevq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .start_mode (request.mode),
        .stat       (stat),
        .cmd        (cmd),
        .load       (load),
        .busy       (busy)
    );

    // Slot store and scan unit: each scan finds the id match, the first free
    // slot and the earliest (time, id) key among pending slots.
    tevq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .req        (request),
        .cmd        (cmd),
        .stat       (stat),
        .rsp        (response),
        .rsp_strobe (response_strobe)
    );

endmodule

// ===== dv/timed_event_queue_tb.sv =====
// Self-checking testbench for the timed event queue: predictor, stimulus tasks, result checker.
module timed_event_queue_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = 32;
    localparam int FIRE_LIMIT = 32;
    localparam longint unsigned CYCLE_LIMIT = 2_000_000;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    tevq_pkg::req_t request;
    tevq_pkg::rsp_t response;
    logic response_strobe;

    timed_event_queue #(.CAPACITY(CAP)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .response(response),
        .response_strobe(response_strobe)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Shadow copy of the event table.
    logic [tevq_pkg::ID_W-1:0]          tbl_id   [CAP];
    logic signed [tevq_pkg::TIME_W-1:0] tbl_time [CAP];
    logic                               tbl_valid[CAP];

    // Response words still owed by the block, oldest first.
    tevq_pkg::rsp_t owed_words[$];

    int  err_count;
    int  words_seen;
    int  fired_seen;
    int  items_sent;
    int  full_drops;
    bit  idle_on;
    longint unsigned cycle_count;

    // Ids scheduled so far (at most 64 kept), so that cancels and reschedules can hit live entries.
    logic [tevq_pkg::ID_W-1:0] id_pool[$];

    // Earliest live slot by (signed time, id); -1 if the table is empty.
    function automatic int earliest_idx();
        int best;
        best = -1;
        for (int i = 0; i < CAP; i++)
        begin
            if (tbl_valid[i])
            begin
                if (best < 0 || tbl_time[i] < tbl_time[best] ||
                    (tbl_time[i] == tbl_time[best] && tbl_id[i] < tbl_id[best]))
                begin
                    best = i;
                end
            end
        end
        return best;
    endfunction

    function automatic int live_count();
        int n;
        n = 0;
        for (int i = 0; i < CAP; i++)
        begin
            if (tbl_valid[i])
            begin
                n++;
            end
        end
        return n;
    endfunction

    function automatic int find_event(logic [tevq_pkg::ID_W-1:0] id);
        for (int i = 0; i < CAP; i++)
        begin
            if (tbl_valid[i] && tbl_id[i] == id)
            begin
                return i;
            end
        end
        return -1;
    endfunction

    // Build one expected word; occupancy fields reflect the table as it is now.
    task automatic owe_word(logic [1:0] kind, logic st, logic [tevq_pkg::ID_W-1:0] fid,
                            logic signed [tevq_pkg::TIME_W-1:0] ft,
                            logic [tevq_pkg::CNT_W-1:0] cnt, logic lst);
        tevq_pkg::rsp_t w;
        int   e;
        e = earliest_idx();
        w.result_kind   = kind;
        w.status        = st;
        w.fired_id      = fid;
        w.fired_time    = ft;
        w.fired_count   = cnt;
        w.pending_count = tevq_pkg::CNT_W'(live_count());
        w.earliest_time = (e < 0) ? tevq_pkg::TIME_MAX : tbl_time[e];
        w.last          = lst;
        owed_words.push_back(w);
    endtask

    // Apply one accepted request to the shadow table and queue its words.
    task automatic predict_queue(tevq_pkg::req_t rq);
        int  i;
        int  k;
        int  e;
        logic dropped;
        logic [tevq_pkg::ID_W-1:0] fid;
        logic signed [tevq_pkg::TIME_W-1:0] ft;
        case (rq.mode)
            tevq_pkg::MODE_SCHED:
            begin
                dropped = 1'b0;
                i = find_event(rq.ev_id);
                if (i >= 0)
                begin
                    tbl_time[i] = rq.time_value;
                end
                else
                begin
                    i = -1;
                    for (int j = 0; j < CAP; j++)
                    begin
                        if (!tbl_valid[j] && i < 0)
                        begin
                            i = j;
                        end
                    end
                    if (i >= 0)
                    begin
                        tbl_valid[i] = 1'b1;
                        tbl_id[i]    = rq.ev_id;
                        tbl_time[i]  = rq.time_value;
                    end
                    else
                    begin
                        dropped = 1'b1;
                        full_drops++;
                    end
                end
                owe_word(tevq_pkg::KIND_SCHED, dropped, '0, '0, '0, 1'b1);
            end
            tevq_pkg::MODE_CANCEL:
            begin
                i = find_event(rq.ev_id);
                if (i >= 0)
                begin
                    tbl_valid[i] = 1'b0;
                end
                owe_word(tevq_pkg::KIND_CANCEL, i >= 0, '0, '0, '0, 1'b1);
            end
            tevq_pkg::MODE_ADVANCE:
            begin
                k = 0;
                while (k < FIRE_LIMIT)
                begin
                    e = earliest_idx();
                    if (e < 0 || tbl_time[e] > rq.time_value)
                    begin
                        break;
                    end
                    fid = tbl_id[e];
                    ft  = tbl_time[e];
                    tbl_valid[e] = 1'b0;
                    owe_word(tevq_pkg::KIND_FIRED, 1'b0, fid, ft, '0, 1'b0);
                    k++;
                end
                owe_word(tevq_pkg::KIND_DONE, 1'b0, '0, '0, tevq_pkg::CNT_W'(k), 1'b1);
            end
            default:
            begin
                // unused mode: no word, no state change
            end
        endcase
    endtask

    // Result checker: every strobed word against the oldest owed word.
    always @(posedge clk)
    begin
        tevq_pkg::rsp_t exp_w;
        cycle_count <= cycle_count + 1;
        if (rst_n && response_strobe)
        begin
            words_seen++;
            if (owed_words.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected word, expected none, actual %p", $time, response);
            end
            else
            begin
                exp_w = owed_words.pop_front();
                if (exp_w.result_kind == tevq_pkg::KIND_FIRED)
                begin
                    fired_seen++;
                end
                if (response !== exp_w)
                begin
                    err_count++;
                    $display("%0t: mismatch, expected %p, actual %p", $time, exp_w, response);
                end
            end
        end
    end

    // Timeout watchdog.
    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Random idle gap about a third of the time while idle gaps are on; start drops for it.
    task automatic maybe_idle();
        int n;
        if (idle_on && $urandom_range(0, 2) == 0)
        begin
            n = $urandom_range(1, 18);
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Send one request word; prediction happens at the accepting edge.
    // start stays high after acceptance so words can follow back to back.
    task automatic send_word(logic [1:0] md, logic [tevq_pkg::ID_W-1:0] id,
                             logic signed [tevq_pkg::TIME_W-1:0] tv);
        tevq_pkg::req_t rq;
        maybe_idle();
        rq.mode       = md;
        rq.ev_id      = id;
        rq.time_value = tv;
        start   <= 1'b1;
        request <= rq;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        // accepted at this edge
        predict_queue(rq);
        items_sent++;
        if (md == tevq_pkg::MODE_SCHED && id_pool.size() < 64)
        begin
            id_pool.push_back(id);
        end
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Small times cluster so that ties and due/not-due splits are common.
    function automatic logic signed [63:0] rand_time();
        case ($urandom_range(0, 5))
            0: return rand64();
            1: return tevq_pkg::TIME_MAX - $urandom_range(0, 3);
            2: return 64'sh8000_0000_0000_0000 + $urandom_range(0, 3);
            default: return $signed(64'($urandom_range(0, 40))) - 20;
        endcase
    endfunction

    function automatic logic [63:0] pick_id();
        if (id_pool.size() > 0 && $urandom_range(0, 3) != 0)
        begin
            return id_pool[$urandom_range(0, id_pool.size() - 1)];
        end
        if ($urandom_range(0, 1))
        begin
            return rand64();
        end
        return 64'($urandom_range(0, 15));
    endfunction

    task automatic drain_wait();
        int n;
        n = 0;
        start <= 1'b0;
        while (owed_words.size() != 0 && n < 200000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (2 * CAP + 20) @(posedge clk);
    endtask

    // Extreme ids and times, ties, reschedule, cancel hit/miss, empty advance.
    task automatic test_directed();
        send_word(tevq_pkg::MODE_ADVANCE, '0, 64'sh0);
        send_word(tevq_pkg::MODE_SCHED, 64'hFFFF_FFFF_FFFF_FFFF, tevq_pkg::TIME_MAX);
        send_word(tevq_pkg::MODE_SCHED, 64'h0, 64'sh8000_0000_0000_0000);
        send_word(tevq_pkg::MODE_SCHED, 64'h5, 64'sd10);
        send_word(tevq_pkg::MODE_SCHED, 64'h3, 64'sd10);
        send_word(tevq_pkg::MODE_SCHED, 64'h5, -64'sd4);
        send_word(tevq_pkg::MODE_CANCEL, 64'h77, '0);
        send_word(tevq_pkg::MODE_CANCEL, 64'h3, '0);
        send_word(tevq_pkg::MODE_SCHED, 64'h3, 64'sd10);
        send_word(MODE_UNUSED, 64'hAAAA_5555_AAAA_5555, -64'sd1);
        send_word(tevq_pkg::MODE_ADVANCE, '0, -64'sd100);
        send_word(tevq_pkg::MODE_ADVANCE, 64'hFFFF_FFFF_FFFF_FFFF, 64'sd10);
        send_word(tevq_pkg::MODE_ADVANCE, '0, tevq_pkg::TIME_MAX);
        drain_wait();
    endtask

    // Fill to capacity, drop a new id, reschedule while full, fire all at once.
    task automatic test_full_table();
        for (int i = 0; i < CAP; i++)
        begin
            send_word(tevq_pkg::MODE_SCHED, 64'(100 + i),
                      $signed(64'($urandom_range(0, 7))));
        end
        send_word(tevq_pkg::MODE_SCHED, 64'h9999, 64'sd1);
        send_word(tevq_pkg::MODE_SCHED, 64'd100, -64'sd50);
        send_word(tevq_pkg::MODE_ADVANCE, '0, tevq_pkg::TIME_MAX);
        drain_wait();
    endtask

    // Mixed random traffic; the last stretch runs with no idle gaps.
    task automatic test_random(int count);
        int r;
        for (int n = 0; n < count; n++)
        begin
            if (n == count - 40)
            begin
                idle_on = 1'b0;
            end
            r = $urandom_range(0, 19);
            if (r < 9)
            begin
                send_word(tevq_pkg::MODE_SCHED, pick_id(), rand_time());
            end
            else if (r < 13)
            begin
                send_word(tevq_pkg::MODE_CANCEL, pick_id(), rand64());
            end
            else if (r < 19)
            begin
                send_word(tevq_pkg::MODE_ADVANCE, rand64(), rand_time());
            end
            else
            begin
                send_word(MODE_UNUSED, rand64(), rand64());
            end
        end
        drain_wait();
    endtask

    initial
    begin
        err_count   = 0;
        words_seen  = 0;
        fired_seen  = 0;
        items_sent  = 0;
        full_drops  = 0;
        cycle_count = 0;
        idle_on     = 1'b1;
        start       = 1'b0;
        request     = '0;
        rst_n       = 1'b0;
        for (int i = 0; i < CAP; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_id[i]    = '0;
            tbl_time[i]  = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_table();
        test_random(255);

        if (owed_words.size() != 0)
        begin
            err_count++;
            $display("%0t: %0d expected words never arrived", $time, owed_words.size());
        end
        $display("Sent %0d requests; checked %0d response words, %0d fired events.",
                 items_sent, words_seen, fired_seen);
        $display("Table-full drops exercised: %0d.", full_drops);
        if (err_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
